FILE: hw/rtl/idle_spin_rate_watchdog_assert.svh
// Assertion macros used by the watchdog top level.
`ifndef IDLE_SPIN_RATE_WATCHDOG_ASSERT_SVH
`define IDLE_SPIN_RATE_WATCHDOG_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISRW_ASSERT_IMP(label, ant, con) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ISRW_ASSERT_NXT(label, ant, con) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/isrw_pkg.sv
// Package: types, constants and control codes of the idle-spin rate watchdog.
`timescale 1ns / 1ps
package isrw_pkg;

    localparam int Depth  = 64;
    localparam int AddrW  = $clog2(Depth);
    localparam int CountW = AddrW + 1;
    localparam int QuotW  = 18;
    localparam int DenW   = 52;
    localparam int NumW   = DenW + QuotW;
    localparam int CfgW   = 22;
    localparam int IdxW   = 3;

    // Configuration register indexes.
    localparam logic [IdxW-1:0] RegEnabled  = 3'd0;
    localparam logic [IdxW-1:0] RegWindow   = 3'd1;
    localparam logic [IdxW-1:0] RegRepeat   = 3'd2;
    localparam logic [IdxW-1:0] RegMinCores = 3'd3;
    localparam logic [IdxW-1:0] RegTps      = 3'd4;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [63:0] cum_ticks;
        logic        idle;
    } in_beat_t;

    typedef struct packed {
        logic        report;
        logic        spinning;
        logic [15:0] cores_q8;
        logic [31:0] spin_start_ms;
        logic [31:0] report_count;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_POP_RD,
        ST_POP_CHK,
        ST_BASE_RD,
        ST_BASE_CHK,
        ST_RATE,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic cap;
        logic push;
        logic clear_push;
        logic rd_en;
        logic rd_base;
        logic pop;
        logic base_calc;
        logic div_start;
        logic clr_rate;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic restart;
        logic cnt_ge2;
        logic pop_ok;
        logic covered;
        logic sat;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/idle_spin_rate_watchdog.sv
// Top level of the idle-spin rate watchdog.
//
//  Channel | Direction | Handshake           | Beat
//  in      | input     | in_valid / in_stall | time_ms, cum_ticks, idle
//  out     | output    | out_valid/out_stall | report, spinning, cores_q8, spin_start_ms,
//          |           |                     | report_count
//  config  | input     | wr_en               | wr_index, wr_data
//
// One sample is processed at a time. When the watchdog is off or the window
// restarts, a sample goes straight to the output; otherwise entries are dropped from
// the ring, the window base is read, a rate is measured if the window is covered,
// and the divide runs unless the rate saturates, one quotient bit a cycle over 18
// bits, before the result is finished.
// A finished beat waits in the output register, so the next sample may be taken
// while out_stall holds it. Reset clears the ring and all spin state at once.
`timescale 1ns / 1ps
`include "idle_spin_rate_watchdog_assert.svh"
module idle_spin_rate_watchdog (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  isrw_pkg::in_beat_t         in_beat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output isrw_pkg::out_beat_t        out_beat,
    input  logic                       wr_en,
    input  logic [isrw_pkg::IdxW-1:0]  wr_index,
    input  logic [isrw_pkg::CfgW-1:0]  wr_data
);

    isrw_pkg::cmd_t    cmd;
    isrw_pkg::status_t stat;

    isrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    isrw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_beat),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    // An accepted sample keeps the input stalled while it is worked on.
    `ISRW_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // A report is only given while spinning.
    `ISRW_ASSERT_IMP(a_report_spinning, out_valid && out_beat.report, out_beat.spinning)
    // A beat is loaded only when the output register is free.
    `ISRW_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free)

endmodule

FILE: hw/rtl/isrw_div.sv
// Restoring divider: floor(delta * 256000 / den) for delta below den, one bit a cycle.
`timescale 1ns / 1ps
module isrw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [isrw_pkg::DenW-1:0]     delta,
    input  logic [isrw_pkg::DenW-1:0]     den,
    output logic                          done,
    output logic [isrw_pkg::QuotW-1:0]    quot
);

    localparam int StepW = $clog2(isrw_pkg::QuotW + 1);

    logic [isrw_pkg::DenW-1:0]  rem_reg, rem_next;
    logic [isrw_pkg::QuotW-1:0] sh_reg, sh_next;
    logic [StepW-1:0]           step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [isrw_pkg::NumW-1:0]  num;
    logic [isrw_pkg::DenW:0]    trial;
    logic                       fits;

    // Numerator: delta * 1000 * 256 as (delta << 18) - (delta << 12) - (delta << 11).
    assign num = ({{isrw_pkg::QuotW{1'b0}}, delta} << 18)
               - ({{isrw_pkg::QuotW{1'b0}}, delta} << 12)
               - ({{isrw_pkg::QuotW{1'b0}}, delta} << 11);

    assign trial = {rem_reg, sh_reg[isrw_pkg::QuotW-1]};
    assign fits  = trial >= {1'b0, den};

    // Shift in one numerator bit and one quotient bit per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = num[isrw_pkg::NumW-1:isrw_pkg::QuotW];
            sh_next   = num[isrw_pkg::QuotW-1:0];
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[isrw_pkg::DenW-1:0] - den
                             : trial[isrw_pkg::DenW-1:0];
            sh_next   = {sh_reg[isrw_pkg::QuotW-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(isrw_pkg::QuotW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

FILE: hw/rtl/isrw_ctrl.sv
// Controller state machine of the watchdog: sequences one sample at a time.
`timescale 1ns / 1ps
module isrw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  isrw_pkg::status_t stat,
    output isrw_pkg::cmd_t    cmd
);

    isrw_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isrw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != isrw_pkg::ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            isrw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = isrw_pkg::ST_CLASS;
                end
            end
            isrw_pkg::ST_CLASS:
            begin
                if (!stat.enabled)
                begin
                    state_next = isrw_pkg::ST_EMIT;
                end
                else if (stat.restart)
                begin
                    cmd.clear_push = 1'b1;
                    cmd.clr_rate   = 1'b1;
                    state_next     = isrw_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = isrw_pkg::ST_POP_RD;
                end
            end
            isrw_pkg::ST_POP_RD:
            begin
                if (stat.cnt_ge2)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = isrw_pkg::ST_POP_CHK;
                end
                else
                begin
                    state_next = isrw_pkg::ST_BASE_RD;
                end
            end
            isrw_pkg::ST_POP_CHK:
            begin
                if (stat.pop_ok)
                begin
                    cmd.pop    = 1'b1;
                    state_next = isrw_pkg::ST_POP_RD;
                end
                else
                begin
                    state_next = isrw_pkg::ST_BASE_RD;
                end
            end
            isrw_pkg::ST_BASE_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_base = 1'b1;
                state_next  = isrw_pkg::ST_BASE_CHK;
            end
            isrw_pkg::ST_BASE_CHK:
            begin
                cmd.base_calc = 1'b1;
                state_next    = isrw_pkg::ST_RATE;
            end
            isrw_pkg::ST_RATE:
            begin
                if (!stat.covered)
                begin
                    cmd.clr_rate = 1'b1;
                    state_next   = isrw_pkg::ST_EMIT;
                end
                else if (stat.sat)
                begin
                    state_next = isrw_pkg::ST_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = isrw_pkg::ST_DIV;
                end
            end
            isrw_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = isrw_pkg::ST_FIN;
                end
            end
            isrw_pkg::ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = isrw_pkg::ST_EMIT;
            end
            isrw_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = isrw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isrw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/isrw_dp.sv
// Datapath of the watchdog: registers, sample ring, rate measurement and output beat.
`timescale 1ns / 1ps
module isrw_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  isrw_pkg::in_beat_t         in_beat,
    input  logic                       wr_en,
    input  logic [isrw_pkg::IdxW-1:0]  wr_index,
    input  logic [isrw_pkg::CfgW-1:0]  wr_data,
    input  isrw_pkg::cmd_t             cmd,
    output isrw_pkg::status_t          stat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output isrw_pkg::out_beat_t        out_beat
);

    localparam int AW = isrw_pkg::AddrW;
    localparam int CW = isrw_pkg::CountW;

    // Configuration registers.
    logic        enabled_reg;
    logic [21:0] window_reg;
    logic [21:0] repeat_reg;
    logic [15:0] min_cores_reg;
    logic [19:0] tps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            window_reg    <= 22'd10000;
            repeat_reg    <= 22'd60000;
            min_cores_reg <= 16'd128;
            tps_reg       <= 20'd100;
        end
        else if (wr_en)
        begin
            case (wr_index)
                isrw_pkg::RegEnabled:  enabled_reg   <= wr_data[0];
                isrw_pkg::RegWindow:   window_reg    <= wr_data;
                isrw_pkg::RegRepeat:   repeat_reg    <= wr_data;
                isrw_pkg::RegMinCores: min_cores_reg <= wr_data[15:0];
                isrw_pkg::RegTps:      tps_reg       <= wr_data[19:0];
                default:               ;
            endcase
        end
    end

    // Captured sample.
    logic [31:0] now_reg;
    logic [63:0] ticks_reg;
    logic        idle_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            now_reg   <= in_beat.time_ms;
            ticks_reg <= in_beat.cum_ticks;
            idle_reg  <= in_beat.idle;
        end
    end

    // Ring pointers and the newest stored time.
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   newest_reg;
    logic          full;
    logic [AW-1:0] head_p;
    logic [CW-1:0] cnt_p;
    logic [AW-1:0] waddr;
    logic          we;

    assign full   = (count_reg == CW'(isrw_pkg::Depth));
    assign head_p = full ? head_reg + 1'b1 : head_reg;
    assign cnt_p  = full ? CW'(isrw_pkg::Depth - 1) : count_reg;
    assign waddr  = cmd.clear_push ? '0 : head_p + cnt_p[AW-1:0];
    assign we     = cmd.push | cmd.clear_push;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear_push)
        begin
            head_next  = '0;
            count_next = CW'(1);
        end
        else if (cmd.push)
        begin
            head_next  = head_p;
            count_next = cnt_p + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            newest_reg <= now_reg;
        end
    end

    // Sample ring memory with registered read.
    logic [31:0]   times_mem [isrw_pkg::Depth];
    logic [63:0]   ticks_mem [isrw_pkg::Depth];
    logic [31:0]   times_q;
    logic [63:0]   ticks_q;
    logic [AW-1:0] rd_addr;

    assign rd_addr = cmd.rd_base ? head_reg : head_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            times_mem[waddr] <= now_reg;
            ticks_mem[waddr] <= ticks_reg;
        end
        if (cmd.rd_en)
        begin
            times_q <= times_mem[rd_addr];
            ticks_q <= ticks_mem[rd_addr];
        end
    end

    // Window base: elapsed time, tick delta and denominator.
    logic [31:0] t0_reg;
    logic [31:0] dt_reg;
    logic [63:0] delta_reg;
    logic [51:0] den_reg;
    logic [19:0] tps_eff;
    logic [31:0] dt_c;

    assign tps_eff = (tps_reg == '0) ? 20'd1 : tps_reg;
    assign dt_c    = now_reg - times_q;

    always_ff @(posedge clk)
    begin
        if (cmd.base_calc)
        begin
            t0_reg    <= times_q;
            dt_reg    <= dt_c;
            delta_reg <= (ticks_reg >= ticks_q) ? ticks_reg - ticks_q : 64'd0;
            den_reg   <= {32'd0, tps_eff} * {20'd0, dt_c};
        end
    end

    // Rate divider.
    logic        div_done;
    logic [17:0] quot;

    isrw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .delta (delta_reg[51:0]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // Spin tracking.
    logic        sat;
    logic [15:0] cores_c;
    logic        repeat_due;
    logic        spin_reg;
    logic [31:0] spin_start_reg;
    logic [31:0] last_rep_reg;
    logic [31:0] reports_reg;
    logic [15:0] cores_reg;
    logic        rep_reg;

    assign sat        = delta_reg >= {12'd0, den_reg};
    assign cores_c    = (sat || quot[17:16] != 2'd0) ? 16'hFFFF : quot[15:0];
    assign repeat_due = (now_reg >= last_rep_reg)
                     && ((now_reg - last_rep_reg) >= {10'd0, repeat_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_reg       <= 1'b0;
            spin_start_reg <= '0;
            last_rep_reg   <= '0;
            reports_reg    <= '0;
            cores_reg      <= '0;
            rep_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.cap)
            begin
                rep_reg <= 1'b0;
            end
            if (cmd.clr_rate)
            begin
                spin_reg  <= 1'b0;
                cores_reg <= '0;
            end
            if (cmd.finish)
            begin
                cores_reg <= cores_c;
                if (cores_c < min_cores_reg)
                begin
                    spin_reg <= 1'b0;
                end
                else if (!spin_reg)
                begin
                    spin_reg       <= 1'b1;
                    spin_start_reg <= t0_reg;
                    last_rep_reg   <= now_reg;
                    reports_reg    <= reports_reg + 1'b1;
                    rep_reg        <= 1'b1;
                end
                else if (repeat_due)
                begin
                    last_rep_reg <= now_reg;
                    reports_reg  <= reports_reg + 1'b1;
                    rep_reg      <= 1'b1;
                end
            end
        end
    end

    // Output beat register.
    logic                out_valid_reg;
    isrw_pkg::out_beat_t out_beat_reg;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_beat_reg.report        <= rep_reg;
            out_beat_reg.spinning      <= spin_reg;
            out_beat_reg.cores_q8      <= cores_reg;
            out_beat_reg.spin_start_ms <= spin_start_reg;
            out_beat_reg.report_count  <= reports_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Status toward the controller.
    assign stat.enabled  = enabled_reg;
    assign stat.restart  = !idle_reg || (count_reg != '0 && now_reg <= newest_reg);
    assign stat.cnt_ge2  = count_reg >= CW'(2);
    assign stat.pop_ok   = ({1'b0, times_q} + {11'd0, window_reg}) <= {1'b0, now_reg};
    assign stat.covered  = (dt_reg >= {10'd0, window_reg}) && (dt_reg != '0);
    assign stat.sat      = sat;
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

endmodule
